/* hw/rtl/skt_pkg.sv */
// ----------------------------------------------------------------------------
// skt_pkg: shared types for the sorted keyed table
// Entry layout, cell command codes, result status codes and request codes.
// ----------------------------------------------------------------------------
package skt_pkg;

	localparam int KEY_W    = 32;
	localparam int STAMP_W  = 32;
	localparam int DATA_W   = 64;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 8;
	localparam int COUNT_W  = 9;

	// request type codes
	localparam logic REQ_UPSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	// one table entry as held in a cell
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [STAMP_W-1:0] stamp;
		logic [DATA_W-1:0]  data;
	} skt_entry_t;

	// command broadcast to every cell in the apply cycle
	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_INSERT,
		CMD_UPDATE,
		CMD_REMOVE
	} skt_cmd_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_UPDATED   = 3'd1,
		ST_STALE     = 3'd2,
		ST_REMOVED   = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_FULL      = 3'd5
	} skt_status_t;

	// per-cell search outcome
	typedef struct packed {
		logic sel;    // first slot with key >= request key (or first empty slot)
		logic hit;    // selected slot holds the request key
		logic newer;  // request stamp is newer than the stored one at a hit
	} skt_flag_t;

endpackage

/* hw/rtl/skt_if.sv */
// ----------------------------------------------------------------------------
// skt_if: request and response channels of the sorted keyed table
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface skt_req_if import skt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               req_type;
	logic [KEY_W-1:0]   entry_key;
	logic [STAMP_W-1:0] entry_time;
	logic [DATA_W-1:0]  entry_data;

	modport source (output valid, req_type, entry_key, entry_time, entry_data, input ready);
	modport sink   (input valid, req_type, entry_key, entry_time, entry_data, output ready);
endinterface

interface skt_rsp_if import skt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot_index;
	logic [COUNT_W-1:0]  entry_count;

	modport source (output valid, status, slot_index, entry_count, input ready);
	modport sink   (input valid, status, slot_index, entry_count, output ready);
endinterface

/* hw/rtl/sorted_keyed_table_upsert.sv */
// ----------------------------------------------------------------------------
// sorted_keyed_table_upsert: sorted table with upsert and remove
// A row of TABLE_DEPTH cells keeps entries sorted by ascending key.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   req_type, entry_key, entry_time, entry_data
//   rsp      out  valid/ready   status, slot_index, entry_count
//
// For each item, in the accept cycle every cell compares its key
// against the request; in the next cycle the cells shift, insert or update
// in one step and the result is loaded into the output register.
// The next item can be accepted in the cycle after that, at the same edge
// that takes the result; a result that waits blocks new items.
// Reset clears the entry count, control state and result; no clearing pass is run.
// ----------------------------------------------------------------------------
module sorted_keyed_table_upsert import skt_pkg::*; #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	skt_req_if.sink   req,
	skt_rsp_if.source rsp
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic {
		S_IDLE,
		S_APPLY
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       fill_q;
	logic [CW-1:0]       fill_nxt;
	logic                op_s1;
	skt_entry_t          req_s1;
	logic                rsp_valid_q;
	skt_status_t         status_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [COUNT_W-1:0]  count_q;

	logic                in_acc;
	logic                full;
	logic                any_hit;
	logic                any_newer;
	logic                slot_use;
	skt_cmd_t            cmd;
	skt_cmd_t            cell_cmd;
	skt_status_t         status_nxt;
	logic [IW-1:0]       pos;

	logic [TABLE_DEPTH-1:0] ge_vec;
	logic [TABLE_DEPTH-1:0] sel_vec;
	logic [TABLE_DEPTH-1:0] hit_vec;
	logic [TABLE_DEPTH-1:0] newer_vec;
	skt_flag_t              flag_vec  [TABLE_DEPTH];
	skt_entry_t             entry_vec [TABLE_DEPTH];

	// handshake
	assign req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign in_acc    = req.valid && req.ready;

	// row of cells
	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		logic       prev_ge;
		skt_entry_t prev_entry;
		skt_entry_t next_entry;

		if (g == 0) begin : g_first
			assign prev_ge    = 1'b0;
			assign prev_entry = req_s1;
		end else begin : g_mid_lo
			assign prev_ge    = ge_vec[g-1];
			assign prev_entry = entry_vec[g-1];
		end

		if (g == TABLE_DEPTH - 1) begin : g_last
			assign next_entry = req_s1;
		end else begin : g_mid_hi
			assign next_entry = entry_vec[g+1];
		end

		skt_cell #(
			.CW  (CW),
			.IDX (g)
		) u_cell (
			.clk        (clk),
			.cmp_en     (in_acc),
			.cmp_key    (req.entry_key),
			.cmp_stamp  (req.entry_time),
			.fill       (fill_q),
			.prev_ge    (prev_ge),
			.prev_entry (prev_entry),
			.next_entry (next_entry),
			.cmd        (cell_cmd),
			.wr_entry   (req_s1),
			.ge         (ge_vec[g]),
			.flag       (flag_vec[g]),
			.entry      (entry_vec[g])
		);

		assign sel_vec[g]   = flag_vec[g].sel;
		assign hit_vec[g]   = flag_vec[g].hit;
		assign newer_vec[g] = flag_vec[g].newer;
	end

	// position of the selected slot
	skt_encode #(
		.N (TABLE_DEPTH),
		.W (IW)
	) u_encode (
		.onehot (sel_vec),
		.index  (pos)
	);

	assign any_hit   = |hit_vec;
	assign any_newer = |newer_vec;
	assign full      = fill_q == CW'(TABLE_DEPTH);

	// decide the operation from the search outcome
	always_comb begin
		cmd        = CMD_NONE;
		status_nxt = ST_NOT_FOUND;
		slot_use   = 1'b0;
		if (op_s1 == REQ_UPSERT) begin
			if (any_hit) begin
				slot_use = 1'b1;
				if (any_newer) begin
					cmd        = CMD_UPDATE;
					status_nxt = ST_UPDATED;
				end else begin
					status_nxt = ST_STALE;
				end
			end else if (full) begin
				status_nxt = ST_FULL;
			end else begin
				cmd        = CMD_INSERT;
				status_nxt = ST_INSERTED;
				slot_use   = 1'b1;
			end
		end else begin
			if (any_hit) begin
				cmd        = CMD_REMOVE;
				status_nxt = ST_REMOVED;
				slot_use   = 1'b1;
			end
		end
	end

	assign cell_cmd = (state_q == S_APPLY) ? cmd : CMD_NONE;

	// entry count after this item
	always_comb begin
		fill_nxt = fill_q;
		if (cmd == CMD_INSERT) begin
			fill_nxt = fill_q + CW'(1);
		end else if (cmd == CMD_REMOVE) begin
			fill_nxt = fill_q - CW'(1);
		end
	end

	// control state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			op_s1       <= REQ_UPSERT;
			req_s1      <= '0;
			rsp_valid_q <= 1'b0;
			status_q    <= ST_INSERTED;
			slot_q      <= '0;
			count_q     <= '0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q      <= S_APPLY;
						op_s1        <= req.req_type;
						req_s1.key   <= req.entry_key;
						req_s1.stamp <= req.entry_time;
						req_s1.data  <= req.entry_data;
					end
				end
				S_APPLY: begin
					state_q     <= S_IDLE;
					fill_q      <= fill_nxt;
					rsp_valid_q <= 1'b1;
					status_q    <= status_nxt;
					slot_q      <= slot_use ? SLOT_W'(pos) : '0;
					count_q     <= COUNT_W'(fill_nxt);
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.slot_index  = slot_q;
	assign rsp.entry_count = count_q;

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY) |-> $onehot0(sel_vec))
		else $error("more than one slot selected");

	a_apply_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY) |-> $past(in_acc))
		else $error("apply cycle without an accepted item");

	a_fill_change: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != $past(fill_q)) |-> $past(state_q == S_APPLY))
		else $error("entry count changed outside the apply cycle");
`endif

endmodule

/* hw/rtl/skt_cell.sv */
// ----------------------------------------------------------------------------
// skt_cell: one slot of the sorted table
// Holds one entry, compares it against the incoming key, and on command
// takes the entry of its left or right neighbor, the new entry, or new data.
// ----------------------------------------------------------------------------
module skt_cell import skt_pkg::*; #(
	parameter int CW  = 9,
	parameter int IDX = 0
) (
	input  logic               clk,
	input  logic               cmp_en,
	input  logic [KEY_W-1:0]   cmp_key,
	input  logic [STAMP_W-1:0] cmp_stamp,
	input  logic [CW-1:0]      fill,
	input  logic               prev_ge,
	input  skt_entry_t         prev_entry,
	input  skt_entry_t         next_entry,
	input  skt_cmd_t           cmd,
	input  skt_entry_t         wr_entry,
	output logic               ge,
	output skt_flag_t          flag,
	output skt_entry_t         entry
);

	skt_entry_t entry_q;
	logic       ge_s1;
	logic       eq_s1;
	logic       newer_s1;
	logic       occ;
	logic       sel;

	assign occ = CW'(IDX) < fill;

	// compare stage: empty slots count as ">= key" so the boundary lands on
	// the first free slot when every stored key is smaller
	always_ff @(posedge clk) begin
		if (cmp_en) begin
			ge_s1    <= !occ || (entry_q.key >= cmp_key);
			eq_s1    <= occ && (entry_q.key == cmp_key);
			newer_s1 <= cmp_stamp > entry_q.stamp;
		end
	end

	// boundary of the thermometer code
	assign sel = ge_s1 && !prev_ge;

	assign ge         = ge_s1;
	assign flag.sel   = sel;
	assign flag.hit   = sel && eq_s1;
	assign flag.newer = sel && eq_s1 && newer_s1;
	assign entry      = entry_q;

	// apply stage: shift, insert or update
	always_ff @(posedge clk) begin
		unique case (cmd)
			CMD_INSERT: begin
				if (sel) begin
					entry_q <= wr_entry;
				end else if (ge_s1) begin
					entry_q <= prev_entry;
				end
			end
			CMD_UPDATE: begin
				if (sel) begin
					entry_q.stamp <= wr_entry.stamp;
					entry_q.data  <= wr_entry.data;
				end
			end
			CMD_REMOVE: begin
				if (ge_s1) begin
					entry_q <= next_entry;
				end
			end
			CMD_NONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule

/* hw/rtl/skt_encode.sv */
// ----------------------------------------------------------------------------
// skt_encode: one-hot to binary encoder
// ORs the index of every set bit; the input has at most one bit set.
// ----------------------------------------------------------------------------
module skt_encode #(
	parameter int N = 256,
	parameter int W = 8
) (
	input  logic [N-1:0] onehot,
	output logic [W-1:0] index
);

	always_comb begin
		index = '0;
		for (int i = 0; i < N; i++) begin
			if (onehot[i]) begin
				index = index | W'(i);
			end
		end
	end

endmodule

/* test/sorted_keyed_table_upsert_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_keyed_table_upsert_test: self-checking bench for the sorted table
// Drives upsert and remove items with random gaps on both channels, keeps its
// own sorted copy of the table to predict each result, and checks every
// result field in order. The table is filled to capacity, then drained, then given a balanced mix.
// ----------------------------------------------------------------------------
module sorted_keyed_table_upsert_test;
	import skt_pkg::*;

	localparam int TABLE_DEPTH = 256;
	localparam int FILL_ITEMS  = 420;
	localparam int DRAIN_ITEMS = 330;
	localparam int MIXED_ITEMS = 280;
	localparam int HOLD_CYCLES = 80;
	localparam int QUEUE_AHEAD = 4;
	localparam longint LIMIT_NS = 2_000_000;

	typedef struct {
		logic               req_type;
		logic [KEY_W-1:0]   key;
		logic [STAMP_W-1:0] stamp;
		logic [DATA_W-1:0]  data;
	} table_req_t;

	typedef struct {
		skt_status_t        status;
		logic [SLOT_W-1:0]  slot;
		logic [COUNT_W-1:0] count;
	} table_rsp_t;

	logic clk;
	logic arst_n;

	skt_req_if req_ch ();
	skt_rsp_if rsp_ch ();

	sorted_keyed_table_upsert #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// predicted table contents, sorted by key
	skt_entry_t table_rows[$];
	table_req_t pending_reqs[$];
	table_rsp_t expected_rsps[$];
	table_req_t drive_req;
	table_req_t taken_req;
	table_rsp_t got_rsp;

	int offered_cnt  = 0;
	int accepted_cnt = 0;
	int error_cnt    = 0;
	int src_idle_pct = 36;
	int snk_idle_pct = 62;
	int hold_asked   = 0;
	int hold_done    = 0;
	int hold_left    = 0;

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#(LIMIT_NS);
		$display("TEST FAILED");
		$finish;
	end

	// lower-bound search: first row whose key is not below the given key
	function automatic int first_not_below(logic [KEY_W-1:0] key);
		int pos;
		pos = 0;
		while (pos < table_rows.size() && table_rows[pos].key < key)
			pos++;
		return pos;
	endfunction

	// apply one request to the predicted table and return its result
	function automatic table_rsp_t apply_request(table_req_t rq);
		table_rsp_t r;
		skt_entry_t e;
		int pos;
		bit hit;
		pos = first_not_below(rq.key);
		hit = (pos < table_rows.size()) && (table_rows[pos].key == rq.key);
		r.slot = '0;
		if (rq.req_type == REQ_UPSERT) begin
			if (hit) begin
				r.slot = pos[SLOT_W-1:0];
				if (rq.stamp > table_rows[pos].stamp) begin
					table_rows[pos].stamp = rq.stamp;
					table_rows[pos].data  = rq.data;
					r.status = ST_UPDATED;
				end else begin
					r.status = ST_STALE;
				end
			end else if (table_rows.size() >= TABLE_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				e.key   = rq.key;
				e.stamp = rq.stamp;
				e.data  = rq.data;
				table_rows.insert(pos, e);
				r.slot   = pos[SLOT_W-1:0];
				r.status = ST_INSERTED;
			end
		end else if (hit) begin
			table_rows.delete(pos);
			r.slot   = pos[SLOT_W-1:0];
			r.status = ST_REMOVED;
		end else begin
			r.status = ST_NOT_FOUND;
		end
		r.count = COUNT_W'(table_rows.size());
		return r;
	endfunction

	// request driver: a new item only once the previous one was taken
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || accepted_cnt == offered_cnt) begin
			if (pending_reqs.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
				drive_req = pending_reqs.pop_front();
				req_ch.req_type   <= drive_req.req_type;
				req_ch.entry_key  <= drive_req.key;
				req_ch.entry_time <= drive_req.stamp;
				req_ch.entry_data <= drive_req.data;
				req_ch.valid      <= 1'b1;
				offered_cnt++;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// result ready: long hold-off on request, else random stalls
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			rsp_ch.ready <= 1'b0;
			hold_left--;
		end else if (hold_asked != hold_done) begin
			hold_done = hold_asked;
			hold_left = HOLD_CYCLES;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// check results first, then predict for the item taken at this edge
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_rsps.size() == 0) begin
				$error("result with no item outstanding: status %0d slot %0d count %0d",
					rsp_ch.status, rsp_ch.slot_index, rsp_ch.entry_count);
				error_cnt++;
			end else begin
				got_rsp = expected_rsps.pop_front();
				if (rsp_ch.status !== got_rsp.status) begin
					$error("status: expected %0d, got %0d", got_rsp.status, rsp_ch.status);
					error_cnt++;
				end
				if (rsp_ch.slot_index !== got_rsp.slot) begin
					$error("slot_index: expected %0d, got %0d", got_rsp.slot,
						rsp_ch.slot_index);
					error_cnt++;
				end
				if (rsp_ch.entry_count !== got_rsp.count) begin
					$error("entry_count: expected %0d, got %0d", got_rsp.count,
						rsp_ch.entry_count);
					error_cnt++;
				end
			end
		end
		if (arst_n && req_ch.valid && req_ch.ready) begin
			taken_req.req_type = req_ch.req_type;
			taken_req.key      = req_ch.entry_key;
			taken_req.stamp    = req_ch.entry_time;
			taken_req.data     = req_ch.entry_data;
			expected_rsps.insert(expected_rsps.size(), apply_request(taken_req));
			accepted_cnt++;
		end
	end

	task automatic queue_request(logic op, logic [KEY_W-1:0] key,
			logic [STAMP_W-1:0] stamp, logic [DATA_W-1:0] data);
		table_req_t rq;
		rq.req_type = op;
		rq.key      = key;
		rq.stamp    = stamp;
		rq.data     = data;
		while (pending_reqs.size() >= QUEUE_AHEAD)
			@(posedge clk);
		pending_reqs.insert(pending_reqs.size(), rq);
	endtask

	task automatic wait_all_done();
		while (pending_reqs.size() > 0 || accepted_cnt != offered_cnt ||
				expected_rsps.size() > 0)
			@(posedge clk);
	endtask

	// key choice: a present key, a small key, a wide key or an extreme
	function automatic logic [KEY_W-1:0] pick_key(int hit_pct);
		int roll;
		roll = $urandom_range(99);
		if (table_rows.size() > 0 && roll < hit_pct)
			return table_rows[$urandom_range(table_rows.size() - 1)].key;
		roll = $urandom_range(99);
		if (roll < 60)
			return KEY_W'($urandom_range(999));
		if (roll < 90)
			return $urandom;
		case ($urandom_range(3))
			0:       return '0;
			1:       return KEY_W'(1);
			2:       return 32'hFFFF_FFFE;
			default: return '1;
		endcase
	endfunction

	// stamp near the stored one for present keys: older, equal or newer
	function automatic logic [STAMP_W-1:0] pick_stamp(logic [KEY_W-1:0] key);
		int pos;
		logic [STAMP_W-1:0] stored;
		pos = first_not_below(key);
		if (pos >= table_rows.size() || table_rows[pos].key != key)
			return $urandom;
		stored = table_rows[pos].stamp;
		case ($urandom_range(2))
			0:       return (stored > 20) ? stored - $urandom_range(1, 20) : '0;
			1:       return stored;
			default: return (stored < 32'hFFFF_FFEC) ? stored + $urandom_range(1, 20) : '1;
		endcase
	endfunction

	task automatic random_phase(int count, int upsert_pct, int hit_pct);
		logic op;
		logic [KEY_W-1:0] key;
		for (int i = 0; i < count; i++) begin
			op  = ($urandom_range(99) < upsert_pct) ? REQ_UPSERT : REQ_REMOVE;
			key = pick_key(hit_pct);
			queue_request(op, key, pick_stamp(key), {$urandom, $urandom});
		end
	endtask

	// stimulus
	initial begin
		req_ch.valid      = 1'b0;
		req_ch.req_type   = REQ_UPSERT;
		req_ch.entry_key  = '0;
		req_ch.entry_time = '0;
		req_ch.entry_data = '0;
		rsp_ch.ready      = 1'b0;
		@(posedge arst_n);

		// directed: empty table, extremes, stale and newer stamps, misses
		queue_request(REQ_REMOVE, 32'd5, '0, '0);
		queue_request(REQ_UPSERT, 32'h8000_0000, 32'd10, 64'h0123_4567_89AB_CDEF);
		queue_request(REQ_UPSERT, '0, '1, '1);
		queue_request(REQ_UPSERT, '1, '0, '0);
		queue_request(REQ_UPSERT, 32'h8000_0000, 32'd10, 64'hDEAD_BEEF_0000_0001);
		queue_request(REQ_UPSERT, 32'h8000_0000, 32'd9, 64'hDEAD_BEEF_0000_0002);
		queue_request(REQ_UPSERT, 32'h8000_0000, 32'd11, 64'hDEAD_BEEF_0000_0003);
		queue_request(REQ_UPSERT, '0, '0, 64'h1);
		queue_request(REQ_UPSERT, '1, '1, 64'h5555_5555_5555_5555);
		queue_request(REQ_REMOVE, 32'h8000_0001, '1, '1);
		queue_request(REQ_REMOVE, '0, '0, '0);
		queue_request(REQ_REMOVE, '1, '0, '0);
		queue_request(REQ_REMOVE, '1, '0, '0);
		queue_request(REQ_UPSERT, 32'h7FFF_FFFF, 32'd1, 64'hAAAA_AAAA_AAAA_AAAA);
		queue_request(REQ_UPSERT, 32'h7FFF_FFFF, 32'd0, '0);
		queue_request(REQ_REMOVE, 32'h8000_0000, '0, '0);
		queue_request(REQ_REMOVE, 32'h7FFF_FFFF, '0, '0);
		queue_request(REQ_REMOVE, '0, '0, '0);

		// fill up past capacity, then drain, then a balanced mix
		random_phase(FILL_ITEMS, 90, 20);
		wait_all_done();
		src_idle_pct = 62;
		snk_idle_pct = 36;
		random_phase(DRAIN_ITEMS, 30, 70);
		wait_all_done();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		hold_asked++;
		random_phase(MIXED_ITEMS, 50, 50);
		wait_all_done();
		repeat (20) @(posedge clk);

		if (error_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
